### src/idfl_pkg.sv
// Shared types and constants for the ID free-list allocator.
package idfl_pkg;

  localparam int FREE_DEPTH_DEF = 256;
  localparam int ID_BITS_DEF    = 16;
  localparam int TID_W          = 16;
  localparam int CFG_W          = 9;
  localparam logic [CFG_W-1:0] CAP_RESET = 9'd64;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_QUERY   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EXHAUSTED = 2'd1,
    STATUS_UNUSED    = 2'd2,
    STATUS_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    op_e              op;
    logic [TID_W-1:0] target_id;
  } req_t;

  typedef struct packed {
    logic [TID_W-1:0] given_id;
    logic             in_use;
    status_e          status;
  } res_t;

endpackage

### src/idfl_ram.sv
// Free-list ring storage: one write port, one read port, registered read data.
module idfl_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/idfl_seq.sv
// Sequencer: init sweep, allocate, and the entry-by-entry free-list scan.
module idfl_seq #(
  parameter int FREE_DEPTH = idfl_pkg::FREE_DEPTH_DEF,
  parameter int ID_BITS    = idfl_pkg::ID_BITS_DEF,
  localparam int IdxW      = $clog2(FREE_DEPTH),
  localparam int CntW      = $clog2(FREE_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                reinit_i,
  input  logic [CntW-1:0]     cap_i,
  input  logic                start,
  output logic                busy,
  input  idfl_pkg::req_t      req_i,
  output logic                done_o,
  output idfl_pkg::res_t      res_o,
  output logic                ram_we_o,
  output logic [IdxW-1:0]     ram_waddr_o,
  output logic [ID_BITS-1:0]  ram_wdata_o,
  output logic [IdxW-1:0]     ram_raddr_o,
  input  logic [ID_BITS-1:0]  ram_rdata_i
);

  import idfl_pkg::*;

  localparam int CW = (ID_BITS > TID_W) ? ID_BITS : TID_W;
  localparam int SW = CntW + 1;

  typedef enum logic [3:0] {
    ST_INIT  = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_ALLOC = 4'b0100,
    ST_SCAN  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [IdxW-1:0]    head_q, head_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [ID_BITS-1:0] highest_q, highest_d;
  logic [IdxW-1:0]    init_q, init_d;
  logic [CntW-1:0]    k_q, k_d;
  logic [IdxW-1:0]    ptr_q, ptr_d;
  logic               pend_q, pend_d;
  logic               done_q, done_d;
  op_e                op_q, op_d;
  logic [TID_W-1:0]   tid_q, tid_d;
  res_t               res_q, res_d;

  logic [SW-1:0]      tail_sum;
  logic [IdxW-1:0]    tail;
  logic               hit;
  logic               scan_end;

  function automatic logic [IdxW-1:0] wrap_inc(input logic [IdxW-1:0] p);
    logic [IdxW-1:0] r;
    if (p == IdxW'(FREE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  // slot just past the newest free entry
  assign tail_sum = SW'(head_q) + SW'(count_q);
  assign tail     = (tail_sum >= SW'(FREE_DEPTH)) ? IdxW'(tail_sum - SW'(FREE_DEPTH))
                                                  : IdxW'(tail_sum);

  // read data arrives the cycle after its address; pend_q marks it as a live entry
  assign hit      = pend_q && (CW'(ram_rdata_i) == CW'(tid_q));
  assign scan_end = hit || ((k_q >= count_q) && !pend_q);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    highest_d   = highest_q;
    init_d      = init_q;
    k_d         = k_q;
    ptr_d       = ptr_q;
    pend_d      = pend_q;
    op_d        = op_q;
    tid_d       = tid_q;
    done_d      = 1'b0;
    res_d       = '{given_id: '0, in_use: 1'b0, status: STATUS_OK};
    ram_we_o    = 1'b0;
    ram_waddr_o = init_q;
    ram_wdata_o = ID_BITS'(init_q);
    ram_raddr_o = (state_q == ST_SCAN) ? ptr_q : head_q;

    case (state_q)
      ST_INIT: begin
        ram_we_o = 1'b1;
        if (init_q == IdxW'(FREE_DEPTH - 1)) begin
          state_d   = ST_IDLE;
          head_d    = '0;
          count_d   = cap_i;
          highest_d = ID_BITS'(cap_i - 1'b1);
        end else begin
          init_d = init_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (start) begin
          op_d  = req_i.op;
          tid_d = req_i.target_id;
          case (req_i.op)
            OP_ALLOC: begin
              if (count_q != '0) begin
                state_d = ST_ALLOC;
              end else begin
                done_d = 1'b1;
                if (highest_q == '1) begin
                  res_d.status = STATUS_EXHAUSTED;
                end else begin
                  highest_d      = highest_q + 1'b1;
                  res_d.given_id = TID_W'(highest_q + 1'b1);
                end
              end
            end
            OP_RELEASE, OP_QUERY: begin
              if (CW'(req_i.target_id) > CW'(highest_q)) begin
                done_d = 1'b1;
                if (req_i.op == OP_RELEASE) begin
                  res_d.status = STATUS_UNUSED;
                end
              end else begin
                state_d = ST_SCAN;
                k_d     = '0;
                ptr_d   = head_q;
                pend_d  = 1'b0;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_ALLOC: begin
        done_d         = 1'b1;
        res_d.given_id = TID_W'(ram_rdata_i);
        head_d         = wrap_inc(head_q);
        count_d        = count_q - 1'b1;
        state_d        = ST_IDLE;
      end
      ST_SCAN: begin
        if (k_q < count_q) begin
          ptr_d  = wrap_inc(ptr_q);
          k_d    = k_q + 1'b1;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (scan_end) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
          pend_d  = 1'b0;
          if (op_q == OP_QUERY) begin
            res_d.in_use = !hit;
          end else if (hit) begin
            res_d.status = STATUS_UNUSED;
          end else if ((CW'(tid_q) == CW'(highest_q)) && (tid_q != '0)) begin
            highest_d = highest_q - 1'b1;
          end else if (count_q == CntW'(FREE_DEPTH)) begin
            res_d.status = STATUS_FULL;
          end else begin
            ram_we_o    = 1'b1;
            ram_waddr_o = tail;
            ram_wdata_o = ID_BITS'(tid_q);
            count_d     = count_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_INIT;
        init_d  = '0;
      end
    endcase

    if (reinit_i) begin
      state_d = ST_INIT;
      init_d  = '0;
      pend_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_INIT;
      head_q    <= '0;
      count_q   <= '0;
      highest_q <= '0;
      init_q    <= '0;
      k_q       <= '0;
      ptr_q     <= '0;
      pend_q    <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      count_q   <= count_d;
      highest_q <= highest_d;
      init_q    <= init_d;
      k_q       <= k_d;
      ptr_q     <= ptr_d;
      pend_q    <= pend_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    tid_q <= tid_d;
    res_q <= res_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### src/id_free_list_allocator_unit.sv
// ID allocator with a FIFO free list: capacity register, sequencer and ring storage.
//
// Allocate, release and query items enter on start while busy is low; each item
// gives one result, shown for one cycle with done_o high and registered the cycle
// after the item's work ends, unless a capacity write cuts a scan short. An allocate
// from an empty free list, and any release or query of an ID above the highest
// issued ID, finish at the accepting edge (busy stays low). An allocate from a
// non-empty list raises busy while the oldest entry is read from the ring memory.
// Release and query otherwise walk the free list through the single ring read
// port, one entry per cycle, stopping at the first match or at the list's end.
// After reset, and after each capacity write, a fill sweep writes all FREE_DEPTH
// ring entries, one entry per cycle, with busy high. Capacity writes are always
// taken (cfg_ready_o is tied high) and restart that sweep. Results cannot be
// stalled, so the receiver must take every done_o cycle.
module id_free_list_allocator_unit #(
  parameter int FREE_DEPTH = idfl_pkg::FREE_DEPTH_DEF,
  parameter int ID_BITS    = idfl_pkg::ID_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  idfl_pkg::req_t             req_i,
  output logic                       done_o,
  output idfl_pkg::res_t             res_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [idfl_pkg::CFG_W-1:0] cfg_data_i
);

  import idfl_pkg::*;

  localparam int IdxW = $clog2(FREE_DEPTH);
  localparam int CntW = $clog2(FREE_DEPTH + 1);
  // largest usable capacity: ring depth, or the whole ID space if smaller
  localparam int CapMax = (ID_BITS < 12 && (1 << ID_BITS) < FREE_DEPTH) ?
                          (1 << ID_BITS) : FREE_DEPTH;

  logic [CFG_W-1:0]   cap_raw_q;
  logic [CntW-1:0]    cap;
  logic               cfg_wr;
  logic               ram_we;
  logic [IdxW-1:0]    ram_waddr;
  logic [ID_BITS-1:0] ram_wdata;
  logic [IdxW-1:0]    ram_raddr;
  logic [ID_BITS-1:0] ram_rdata;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_raw_q <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_raw_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (cap_raw_q == '0) begin
      cap = CntW'(1);
    end else if (32'(cap_raw_q) > 32'(CapMax)) begin
      cap = CntW'(CapMax);
    end else begin
      cap = CntW'(cap_raw_q);
    end
  end

  idfl_seq #(
    .FREE_DEPTH (FREE_DEPTH),
    .ID_BITS    (ID_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .reinit_i    (cfg_wr),
    .cap_i       (cap),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  idfl_ram #(
    .DEPTH (FREE_DEPTH),
    .WIDTH (ID_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
